// ===== src/dwt_db4_multilevel_analysis_macros.svh =====
// assertion helpers used by the dwt controller
`ifndef DWT_DB4_MULTILEVEL_ANALYSIS_MACROS_SVH
`define DWT_DB4_MULTILEVEL_ANALYSIS_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DWT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DWT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dwt_pkg.sv =====
package dwt_pkg;

    // defaults for the top-level parameters
    localparam int TAPS_DEF     = 8;
    localparam int LEVELS_DEF   = 5;
    localparam int SAMPLE_W_DEF = 16;

    // fixed widths
    localparam int COEF_W      = 16;
    localparam int G_W         = COEF_W + 1;
    localparam int DATA_W      = 24;
    localparam int LEVEL_W     = 4;
    localparam int FRAC        = 15;
    localparam int NREGS       = 8;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    // controller to datapath commands
    typedef struct packed {
        logic clr;
        logic load_in;
        logic load_zero;
        logic load_cas;
        logic wr;
        logic acc_clr;
        logic issue;
        logic finish;
        logic push;
        logic release_res;
        logic last;
        logic cnt_clr;
    } t_dp_cmd;

    // datapath status back to the controller
    typedef struct packed {
        logic clr_last;
        logic busy;
        logic keep;
        logic out_room;
    } t_dp_sts;

    // db4 low-pass taps in Q1.15 after reset
    function automatic logic signed [COEF_W-1:0] coef_reset(input int idx);
        logic signed [COEF_W-1:0] v;
        case (idx)
            0:       v = -16'sd347;
            1:       v = 16'sd1078;
            2:       v = 16'sd1011;
            3:       v = -16'sd6129;
            4:       v = -16'sd917;
            5:       v = 16'sd20673;
            6:       v = 16'sd23424;
            7:       v = 16'sd7549;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/dwt_cfg.sv =====
module dwt_cfg #(
    parameter int TAPS = dwt_pkg::TAPS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dwt_pkg::PADDR_W-1:0]           paddr,
    input  logic [dwt_pkg::PDATA_W-1:0]           pwdata,
    output logic [dwt_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic [$clog2(TAPS)-1:0]               i_tap,
    output logic signed [dwt_pkg::COEF_W-1:0]     o_h,
    output logic signed [dwt_pkg::G_W-1:0]        o_g
);
    import dwt_pkg::*;

    logic signed [COEF_W-1:0] r_coef [TAPS];
    logic signed [COEF_W-1:0] r_fwd  [TAPS];
    logic signed [COEF_W-1:0] r_rev  [TAPS];
    logic [2:0]               idx;
    logic                     wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;

    // coefficient register file, kept in readback, forward and reversed copies
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TAPS; i++) begin
            if (!i_rst_n) begin
                r_coef[i]          <= coef_reset(i);
                r_fwd[i]           <= coef_reset(i);
                r_rev[TAPS-1-i]    <= coef_reset(i);
            end else if (wr_en && i < NREGS && int'(idx) == i) begin
                r_coef[i]          <= pwdata[COEF_W-1:0];
                r_fwd[i]           <= pwdata[COEF_W-1:0];
                r_rev[TAPS-1-i]    <= pwdata[COEF_W-1:0];
            end
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        for (int i = 0; i < TAPS; i++) begin
            if (i < NREGS && int'(idx) == i) begin
                prdata = PDATA_W'(r_coef[i]);
            end
        end
    end

    // low-pass tap and alternating-sign reversed high-pass tap
    assign o_h = r_fwd[i_tap];
    assign o_g = i_tap[0] ? G_W'(r_rev[i_tap]) : -G_W'(r_rev[i_tap]);

endmodule

// ===== src/dwt_dp.sv =====
module dwt_dp #(
    parameter int TAPS     = dwt_pkg::TAPS_DEF,
    parameter int LEVELS   = dwt_pkg::LEVELS_DEF,
    parameter int SAMPLE_W = dwt_pkg::SAMPLE_W_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  dwt_pkg::t_dp_cmd                            i_cmd,
    output dwt_pkg::t_dp_sts                            o_sts,
    input  logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] i_k,
    input  logic [$clog2(TAPS)-1:0]                     i_tap,
    input  logic signed [dwt_pkg::COEF_W-1:0]           i_h,
    input  logic signed [dwt_pkg::G_W-1:0]              i_g,
    input  logic signed [SAMPLE_W-1:0]                  i_sample,
    input  logic                                        i_ready,
    output logic                                        o_valid,
    output logic [dwt_pkg::LEVEL_W-1:0]                 o_level,
    output logic signed [dwt_pkg::DATA_W-1:0]           o_approx_coef,
    output logic signed [dwt_pkg::DATA_W-1:0]           o_detail_coef,
    output logic                                        o_last_of_signal
);
    import dwt_pkg::*;

    localparam int SLOT_W = $clog2(TAPS);
    localparam int P      = 2 ** SLOT_W;
    localparam int DEPTH  = LEVELS * P;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = DATA_W + G_W;
    localparam int ACC_W  = PROD_W + SLOT_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (DATA_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2 ** (FRAC - 1));

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]        r_clr_addr;
    logic [SLOT_W-1:0]        r_ptr   [LEVELS];
    logic                     r_phase [LEVELS];
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_rd;
    logic signed [COEF_W-1:0] r_h;
    logic signed [G_W-1:0]    r_g;
    logic                     r_v1;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_pa;
    logic signed [PROD_W-1:0] r_pd;
    logic signed [ACC_W-1:0]  r_acc_a;
    logic signed [ACC_W-1:0]  r_acc_d;
    logic signed [DATA_W-1:0] r_a;
    logic signed [DATA_W-1:0] r_d;
    logic                     r_keep;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_pv;
    logic [LEVEL_W-1:0]       r_pend_lvl;
    logic signed [DATA_W-1:0] r_pend_a;
    logic signed [DATA_W-1:0] r_pend_d;
    logic                     r_ov;
    logic [LEVEL_W-1:0]       r_olvl;
    logic signed [DATA_W-1:0] r_oa;
    logic signed [DATA_W-1:0] r_od;
    logic                     r_olast;

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     room_cnt;
    logic                     load_out;

    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = (acc + HALF) >>> FRAC;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[DATA_W-1:0];
    endfunction

    assign wr_addr = ADDR_W'({i_k, r_ptr[i_k]});
    assign rd_addr = ADDR_W'({i_k, SLOT_W'(r_ptr[i_k] - i_tap)});

    // delay line memory, one ring per level, with clearing sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr) begin
            mem[wr_addr] <= r_x;
        end
        if (i_cmd.issue) begin
            r_rd <= mem[rd_addr];
            r_h  <= i_h;
            r_g  <= i_g;
        end
    end

    // ring pointers, phase bits and clear address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            for (int i = 0; i < LEVELS; i++) begin
                r_ptr[i]   <= '0;
                r_phase[i] <= 1'b0;
            end
        end else if (i_cmd.clr) begin
            r_clr_addr <= (r_clr_addr == ADDR_W'(DEPTH - 1)) ? '0 : r_clr_addr + 1'b1;
            for (int i = 0; i < LEVELS; i++) begin
                r_ptr[i]   <= '0;
                r_phase[i] <= 1'b0;
            end
        end else if (i_cmd.finish) begin
            r_ptr[i_k]   <= r_ptr[i_k] + 1'b1;
            r_phase[i_k] <= ~r_phase[i_k];
        end
    end

    // stage input register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= DATA_W'(i_sample);
        end else if (i_cmd.load_zero) begin
            r_x <= '0;
        end else if (i_cmd.load_cas) begin
            r_x <= r_a;
        end
    end

    // multiply and accumulate pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
        r_pa <= r_rd * r_h;
        r_pd <= r_rd * r_g;
        if (i_cmd.acc_clr) begin
            r_acc_a <= '0;
            r_acc_d <= '0;
        end else if (r_v2) begin
            r_acc_a <= r_acc_a + ACC_W'(r_pa);
            r_acc_d <= r_acc_d + ACC_W'(r_pd);
        end
        if (i_cmd.finish) begin
            r_a    <= round_sat(r_acc_a);
            r_d    <= round_sat(r_acc_d);
            r_keep <= ~r_phase[i_k];
        end
    end

    assign room_cnt = (r_cnt < CNT_W'(MAX_RESULTS));
    assign load_out = r_pv && ((i_cmd.push && room_cnt) || i_cmd.release_res);

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.push && room_cnt) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.push && room_cnt) begin
                r_pv <= 1'b1;
            end else if (i_cmd.release_res) begin
                r_pv <= 1'b0;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
        if (load_out) begin
            r_olvl  <= r_pend_lvl;
            r_oa    <= r_pend_a;
            r_od    <= r_pend_d;
            r_olast <= i_cmd.release_res && i_cmd.last;
        end
        if (i_cmd.push && room_cnt) begin
            r_pend_lvl <= LEVEL_W'(i_k) + 1'b1;
            r_pend_a   <= r_a;
            r_pend_d   <= r_d;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_sts.busy     = r_v1 || r_v2;
    assign o_sts.keep     = r_keep;
    assign o_sts.out_room = !r_pv || !r_ov || i_ready;

    assign o_valid          = r_ov;
    assign o_level          = r_olvl;
    assign o_approx_coef    = r_oa;
    assign o_detail_coef    = r_od;
    assign o_last_of_signal = r_olast;

endmodule

// ===== src/dwt_ctrl.sv =====
module dwt_ctrl #(
    parameter int TAPS   = dwt_pkg::TAPS_DEF,
    parameter int LEVELS = dwt_pkg::LEVELS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    input  logic                                        i_end_of_signal,
    output logic                                        o_ready,
    output dwt_pkg::t_dp_cmd                            o_cmd,
    input  dwt_pkg::t_dp_sts                            i_sts,
    output logic [((LEVELS > 1) ? $clog2(LEVELS) : 1)-1:0] o_k,
    output logic [$clog2(TAPS)-1:0]                     o_tap
);
    import dwt_pkg::*;
    `include "dwt_db4_multilevel_analysis_macros.svh"

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W = $clog2(TAPS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WRITE = 3'd2;
    localparam logic [2:0] S_MAC   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [LVL_W-1:0]  r_k, n_k;
    logic [SLOT_W-1:0] r_tap, n_tap;
    logic              r_eos, n_eos;
    logic              r_flush, n_flush;
    logic [LVL_W-1:0]  r_fk, n_fk;
    logic [SLOT_W-1:0] r_fz, n_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_tap   <= '0;
            r_eos   <= 1'b0;
            r_flush <= 1'b0;
            r_fk    <= '0;
            r_fz    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_tap   <= n_tap;
            r_eos   <= n_eos;
            r_flush <= n_flush;
            r_fk    <= n_fk;
            r_fz    <= n_fz;
        end
    end

    // sequencer: one stage push at a time, cascade depth first, then flush
    always_comb begin
        logic cas_done;
        cas_done = 1'b0;
        n_state  = r_state;
        n_k      = r_k;
        n_tap    = r_tap;
        n_eos    = r_eos;
        n_flush  = r_flush;
        n_fk     = r_fk;
        n_fz     = r_fz;
        o_cmd    = '0;
        o_ready  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_eos   = i_end_of_signal;
                    n_flush = 1'b0;
                    n_k     = '0;
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.wr      = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_tap   = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_tap = r_tap + 1'b1;
                if (r_tap == SLOT_W'(TAPS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_sts.keep) begin
                    cas_done = 1'b1;
                end else if (i_sts.out_room) begin
                    o_cmd.push = 1'b1;
                    if (r_k == LVL_W'(LEVELS - 1)) begin
                        cas_done = 1'b1;
                    end else begin
                        o_cmd.load_cas = 1'b1;
                        n_k     = r_k + 1'b1;
                        n_state = S_WRITE;
                    end
                end
            end
            S_FINAL: begin
                if (i_sts.out_room) begin
                    o_cmd.release_res = 1'b1;
                    o_cmd.last        = r_eos;
                    n_state = r_eos ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase

        // cascade finished: next flush zero or wrap up the transaction
        if (cas_done) begin
            if (!r_eos) begin
                n_state = S_FINAL;
            end else if (!r_flush) begin
                o_cmd.load_zero = 1'b1;
                n_flush = 1'b1;
                n_fk    = '0;
                n_fz    = '0;
                n_k     = '0;
                n_state = S_WRITE;
            end else if (r_fz == SLOT_W'(TAPS - 2)) begin
                if (r_fk == LVL_W'(LEVELS - 1)) begin
                    n_state = S_FINAL;
                end else begin
                    o_cmd.load_zero = 1'b1;
                    n_fk    = r_fk + 1'b1;
                    n_fz    = '0;
                    n_k     = r_fk + 1'b1;
                    n_state = S_WRITE;
                end
            end else begin
                o_cmd.load_zero = 1'b1;
                n_fz    = r_fz + 1'b1;
                n_k     = r_fk;
                n_state = S_WRITE;
            end
        end
    end

    assign o_k   = r_k;
    assign o_tap = r_tap;

    // checks
    `DWT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, o_ready && i_valid, r_state == S_WRITE, "accepted transaction did not start a stage push")
    `DWT_ASSERT_NOW(a_level_range, i_clk, i_rst_n, 1'b1, r_k <= LVL_W'(LEVELS - 1) && r_fk <= LVL_W'(LEVELS - 1), "level index out of range")
    `DWT_ASSERT_NEXT(a_mac_busy, i_clk, i_rst_n, r_state == S_MAC, i_sts.busy, "tap issue did not reach the multiply pipeline")
    `DWT_ASSERT_NOW(a_flush_eos, i_clk, i_rst_n, r_flush && r_state != S_IDLE, r_eos, "flush running without end of signal")

endmodule

// ===== src/dwt_db4_multilevel_analysis.sv =====
// Multilevel db4 wavelet analysis over a stream of signed samples. Each level runs a
// zero-padded TAPS-tap convolution, keeps even output indexes and emits an
// (approximation, detail) pair tagged with its level; kept approximations feed the next
// level at once, so pairs come in level order. A sample with end_of_signal flushes TAPS-1
// zeros through every level, flags the final pair with last_of_signal and clears all
// delay lines. One shared multiply-accumulate unit and a single-port delay-line memory do
// all the work: each stage push is one write, TAPS tap reads, a drain of the multiply
// pipeline and one emit, and a transaction is the accept, one push plus one per kept pair
// that cascades and a wrap-up, plus the flush pushes on an end of signal; a stalled result
// port stretches the emit and wrap-up steps. After reset and after every end of signal a
// clearing pass over all LEVELS*2^clog2(TAPS) delay-line words (40 with defaults) runs
// before the next sample is taken. The coefficient registers sit on the APB port at byte
// address 4*i and read back.
module dwt_db4_multilevel_analysis #(
    parameter int TAPS     = dwt_pkg::TAPS_DEF,
    parameter int LEVELS   = dwt_pkg::LEVELS_DEF,
    parameter int SAMPLE_W = dwt_pkg::SAMPLE_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SAMPLE_W-1:0]        i_sample,
    input  logic                              i_end_of_signal,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [dwt_pkg::LEVEL_W-1:0]       o_level,
    output logic signed [dwt_pkg::DATA_W-1:0] o_approx_coef,
    output logic signed [dwt_pkg::DATA_W-1:0] o_detail_coef,
    output logic                              o_last_of_signal,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dwt_pkg::PADDR_W-1:0]       paddr,
    input  logic [dwt_pkg::PDATA_W-1:0]       pwdata,
    output logic [dwt_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import dwt_pkg::*;

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W = $clog2(TAPS);

    t_dp_cmd                  cmd;
    t_dp_sts                  sts;
    logic [LVL_W-1:0]         k;
    logic [SLOT_W-1:0]        tap;
    logic signed [COEF_W-1:0] h;
    logic signed [G_W-1:0]    g;

    // coefficient registers
    dwt_cfg #(
        .TAPS (TAPS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_tap   (tap),
        .o_h     (h),
        .o_g     (g)
    );

    // sequencer
    dwt_ctrl #(
        .TAPS   (TAPS),
        .LEVELS (LEVELS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_end_of_signal (i_end_of_signal),
        .o_ready         (o_ready),
        .o_cmd           (cmd),
        .i_sts           (sts),
        .o_k             (k),
        .o_tap           (tap)
    );

    // delay lines, multiply-accumulate and result registers
    dwt_dp #(
        .TAPS     (TAPS),
        .LEVELS   (LEVELS),
        .SAMPLE_W (SAMPLE_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_k              (k),
        .i_tap            (tap),
        .i_h              (h),
        .i_g              (g),
        .i_sample         (i_sample),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_level          (o_level),
        .o_approx_coef    (o_approx_coef),
        .o_detail_coef    (o_detail_coef),
        .o_last_of_signal (o_last_of_signal)
    );

endmodule
